>>> rtl/core/pst_pkg.sv
// Shared constants and types for the prime sieve table block.
package pst_pkg;

  // Largest number covered by the bitmap
  localparam int unsigned MAX_NUMBER = 4095;
  localparam int unsigned NUM_W      = 12;
  localparam int unsigned WALK_W     = NUM_W + 1;
  localparam int unsigned ROOT_W     = 7;

  // Opcodes of an input beat
  localparam logic OP_BUILD = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Status codes of a result beat
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_RANGE     = 2'd1;
  localparam logic [1:0] STATUS_NOT_BUILT = 2'd2;

  // Smallest prime
  localparam logic [ROOT_W-1:0] FIRST_PRIME = ROOT_W'(2);

  // Bitmap write and read requests
  typedef struct packed {
    logic             en;
    logic [NUM_W-1:0] addr;
    logic             data;
  } bm_wr_t;

  typedef struct packed {
    logic             en;
    logic [NUM_W-1:0] addr;
  } bm_rd_t;

endpackage

>>> rtl/core/pst_bitmap.sv
// Composite bitmap: one bit per number, one write and one registered read port.
module pst_bitmap
  import pst_pkg::*;
(
  input  logic   clk,
  input  bm_wr_t wr,
  input  bm_rd_t rd,
  output logic   rd_data
);

  logic mem [0:MAX_NUMBER];

  // Write one bit
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Register the read bit
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

>>> rtl/core/prime_sieve_table_top.sv
// Sieve of Eratosthenes engine with primality lookup, top level.
//
// Input channel (in_valid/in_stall) carries op and query_number; one beat
// is taken when in_valid is high and in_stall low. Each input beat gives
// exactly one result beat on out_valid/out_stall (is_prime, status).
// cfg_we writes cfg_data into the sieve limit, used by the next build.
// A query goes from acceptance to out_valid through bitmap read, then
// compare, then output load; a query before any build or above the
// built limit skips the read.
// A build first clears each bitmap entry up to the limit, then for each
// candidate p with p*p up to the limit reads bit p and, if p is prime,
// marks its multiples from p*p up to the limit with the walk adder
// (multiple += p) through the one bitmap write port.
// in_stall is high from acceptance until the result is loaded.
// Reset (rst, synchronous) clears the built flag, the built limit and the
// output valid and sets the limit to 30; the bitmap is not cleared then,
// since queries before a build never read it.
// When the receiver stalls, the result is held in the output register and
// the next input beat is still taken; its result waits until that
// register frees.
module prime_sieve_table_top
  import pst_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [NUM_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             op,
  input  logic [NUM_W-1:0] query_number,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             is_prime,
  output logic [1:0]       status
);

  // Sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_QWAIT = 3'd1;
  localparam logic [2:0] ST_CLEAR = 3'd2;
  localparam logic [2:0] ST_CHECK = 3'd3;
  localparam logic [2:0] ST_CWAIT = 3'd4;
  localparam logic [2:0] ST_MARK  = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]        state, state_next;
  logic [NUM_W-1:0]  limit_cfg;
  logic              sieve_built, sieve_built_next;
  logic [NUM_W-1:0]  built_limit, built_limit_next;
  logic [NUM_W-1:0]  lim, lim_next;
  logic [NUM_W-1:0]  qnum, qnum_next;
  logic [WALK_W-1:0] walk, walk_next;
  logic [ROOT_W-1:0] p, p_next;
  logic [WALK_W-1:0] sq, sq_next;
  logic              res_prime, res_prime_next;
  logic [1:0]        res_status, res_status_next;
  logic              out_load;
  logic              in_take;
  logic              out_free;
  logic [WALK_W-1:0] walk_sum;
  logic [WALK_W-1:0] sq_step;
  logic [WALK_W-1:0] lim_ext;
  bm_wr_t            bm_wr;
  bm_rd_t            bm_rd;
  logic              bm_bit;

  pst_bitmap u_bitmap (
    .clk     (clk),
    .wr      (bm_wr),
    .rd      (bm_rd),
    .rd_data (bm_bit)
  );

  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign lim_ext  = {1'b0, lim};

  // Walk adder and the square of p + 1 from the running square of p
  assign walk_sum = walk + WALK_W'(p);
  assign sq_step  = sq + WALK_W'({p, 1'b1});

  // Sequencer
  always_comb begin
    state_next       = state;
    sieve_built_next = sieve_built;
    built_limit_next = built_limit;
    lim_next         = lim;
    qnum_next        = qnum;
    walk_next        = walk;
    p_next           = p;
    sq_next          = sq;
    res_prime_next   = res_prime;
    res_status_next  = res_status;
    out_load         = 1'b0;
    bm_wr            = '{en: 1'b0, addr: walk[NUM_W-1:0], data: 1'b0};
    bm_rd            = '{en: 1'b0, addr: query_number};
    unique case (state)
      ST_IDLE: begin
        if (in_take) begin
          qnum_next       = query_number;
          res_prime_next  = 1'b0;
          res_status_next = STATUS_OK;
          if (op == OP_BUILD) begin
            // Limit is 12 bits, so it never exceeds MAX_NUMBER
            lim_next   = limit_cfg;
            walk_next  = '0;
            state_next = ST_CLEAR;
          end else if (!sieve_built) begin
            res_status_next = STATUS_NOT_BUILT;
            state_next      = ST_DONE;
          end else if (query_number > built_limit) begin
            res_status_next = STATUS_RANGE;
            state_next      = ST_DONE;
          end else begin
            bm_rd.en   = 1'b1;
            state_next = ST_QWAIT;
          end
        end
      end
      ST_QWAIT: begin
        res_prime_next = (qnum >= NUM_W'(FIRST_PRIME)) && !bm_bit;
        state_next     = ST_DONE;
      end
      ST_CLEAR: begin
        // Clear one entry a cycle up to the limit
        bm_wr.en = 1'b1;
        if (walk == lim_ext) begin
          p_next     = FIRST_PRIME;
          sq_next    = WALK_W'(4);
          state_next = ST_CHECK;
        end else begin
          walk_next = walk + WALK_W'(1);
        end
      end
      ST_CHECK: begin
        if (sq > lim_ext) begin
          built_limit_next = lim;
          sieve_built_next = 1'b1;
          state_next       = ST_DONE;
        end else begin
          bm_rd.en   = 1'b1;
          bm_rd.addr = NUM_W'(p);
          state_next = ST_CWAIT;
        end
      end
      ST_CWAIT: begin
        if (!bm_bit) begin
          walk_next  = sq;
          state_next = ST_MARK;
        end else begin
          p_next     = p + ROOT_W'(1);
          sq_next    = sq_step;
          state_next = ST_CHECK;
        end
      end
      ST_MARK: begin
        // Mark multiples of p from p*p up to the limit
        if (walk > lim_ext) begin
          p_next     = p + ROOT_W'(1);
          sq_next    = sq_step;
          state_next = ST_CHECK;
        end else begin
          bm_wr.en   = 1'b1;
          bm_wr.data = 1'b1;
          walk_next  = walk_sum;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      sieve_built <= 1'b0;
      built_limit <= '0;
      limit_cfg   <= NUM_W'(30);
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      sieve_built <= sieve_built_next;
      built_limit <= built_limit_next;
      if (cfg_we) begin
        limit_cfg <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    lim        <= lim_next;
    qnum       <= qnum_next;
    walk       <= walk_next;
    p          <= p_next;
    sq         <= sq_next;
    res_prime  <= res_prime_next;
    res_status <= res_status_next;
    if (out_load) begin
      is_prime <= res_prime;
      status   <= res_status;
    end
  end

`ifndef ASSERT_OFF
  // Bitmap is written only while building
  a_write_in_build: assert property (@(posedge clk) disable iff (rst)
    bm_wr.en |-> (state == ST_CLEAR || state == ST_MARK))
    else $error("bitmap written outside a build");

  // Writes never go beyond the build limit
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    bm_wr.en |-> (walk <= lim_ext))
    else $error("bitmap write above limit");

  // A prime answer always comes with status ok
  a_prime_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_prime) |-> (status == STATUS_OK))
    else $error("prime reported with error status");

  // Once built, the sieve stays built
  a_built_sticky: assert property (@(posedge clk) disable iff (rst)
    sieve_built |=> sieve_built)
    else $error("built flag dropped");
`endif

endmodule
